>>> src/itoa_pkg.sv
// shared constants, types and tables for the integer to ascii formatter
package itoa_pkg;

	// field widths of the channels
	localparam int IN_VALUE_W = 64;
	localparam int RADIX_W    = 2;
	localparam int MIN_W      = 7;
	localparam int CHAR_W     = 8;

	// sizing of the conversion
	localparam int VALUE_BITS = 64;
	localparam int MAX_WIDTH  = 64;
	localparam int CAPACITY   = 64;
	localparam int DEC_DEPTH  = 20;
	localparam int PAD_LIMIT  = (MAX_WIDTH < CAPACITY) ? MAX_WIDTH : CAPACITY;

	// double dabble runs two bits per cycle
	localparam int DD_STEPS = (VALUE_BITS + 1) / 2;
	localparam int DD_BITS  = 2 * DD_STEPS;
	localparam int POS_W    = $clog2(DD_BITS);

	localparam int BCD_W  = 4 * DEC_DEPTH;
	localparam int DATA_W = (BCD_W > VALUE_BITS) ? BCD_W : VALUE_BITS;
	localparam int LEN_W  = $clog2(CAPACITY + 1);
	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int DIG_W  = $clog2(DEC_DEPTH);

	// request queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [CHAR_W-1:0] SEP_RESET = 8'd44;
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;

	localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
	};

	typedef enum logic [RADIX_W-1:0] {
		RADIX_DEC = 2'd0,
		RADIX_BIN = 2'd1,
		RADIX_OCT = 2'd2,
		RADIX_HEX = 2'd3
	} radix_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_CONV,
		FR_DONE
	} front_state_t;

	// one classified number, ready for emission
	typedef struct packed {
		logic              is_dec;
		logic              grp;
		radix_t            radix;
		logic [LEN_W-1:0]  len;
		logic [LEN_W-1:0]  pad;
		logic [DIG_W-1:0]  top;
		logic [1:0]        top_m3;
		logic [DATA_W-1:0] data;
	} job_t;

	// queue status seen by the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

>>> src/itoa_if.sv
// request and character channel interfaces
interface itoa_req_if;
	logic                            valid;
	logic                            ready;
	logic [itoa_pkg::IN_VALUE_W-1:0] value;
	logic [itoa_pkg::RADIX_W-1:0]    radix;
	logic [itoa_pkg::MIN_W-1:0]      min_digits;
	logic                            group;

	modport source (output valid, value, radix, min_digits, group, input ready);
	modport sink   (input valid, value, radix, min_digits, group, output ready);
endinterface

interface itoa_char_if;
	logic                        valid;
	logic                        ready;
	logic [itoa_pkg::CHAR_W-1:0] character;
	logic                        last;

	modport source (output valid, character, last, input ready);
	modport sink   (input valid, character, last, output ready);
endinterface

>>> src/itoa_front.sv
// front: accepts a request, converts to bcd and finds the text length
module itoa_front (
	input  logic               clk,
	input  logic               arst_n,
	itoa_req_if.sink           req,
	input  itoa_pkg::fifo_stat_t stat,
	output logic               push,
	output itoa_pkg::job_t     job
);

	itoa_pkg::front_state_t state_q, state_d;

	logic [itoa_pkg::DD_BITS-1:0]    shift_q;
	logic [itoa_pkg::VALUE_BITS-1:0] val_q;
	logic [itoa_pkg::BCD_W-1:0]      bcd_q;
	logic [itoa_pkg::POS_W-1:0]      pos_q;
	logic [itoa_pkg::POS_W-1:0]      msb_q;
	logic                            found_q;
	itoa_pkg::radix_t                radix_q;
	logic [itoa_pkg::LEN_W-1:0]      pad_q;
	logic                            grp_q;

	logic                            accept;
	logic [itoa_pkg::LEN_W-1:0]      pad_clamped;
	logic [itoa_pkg::LEN_W-1:0]      ndig_dec;
	logic [itoa_pkg::LEN_W-1:0]      msb_ext;
	logic [itoa_pkg::LEN_W-1:0]      ndig;
	logic [itoa_pkg::LEN_W-1:0]      top_ext;
	logic [itoa_pkg::LEN_W-1:0]      top_div;
	logic [itoa_pkg::LEN_W-1:0]      nsep;
	logic [itoa_pkg::LEN_W-1:0]      natural_len;
	logic [itoa_pkg::LEN_W-1:0]      len;
	logic                            grp_eff;

	// one double dabble bit: add 3 to digits of 5 and up, then shift the bit in
	function automatic logic [itoa_pkg::BCD_W-1:0] dd_bit(
		input logic [itoa_pkg::BCD_W-1:0] b,
		input logic                       in_bit
	);
		logic [itoa_pkg::BCD_W-1:0] adj;
		logic [3:0]                 d;
		for (int k = 0; k < itoa_pkg::DEC_DEPTH; k++) begin
			d = b[4*k +: 4];
			adj[4*k +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
		end
		return {adj[itoa_pkg::BCD_W-2:0], in_bit};
	endfunction

	// floor of x / 3 through the reciprocal 43 / 128, exact below 128
	function automatic logic [itoa_pkg::LEN_W-1:0] div3(
		input logic [itoa_pkg::LEN_W-1:0] x
	);
		logic [itoa_pkg::LEN_W+5:0] p;
		p = (itoa_pkg::LEN_W+6)'(x) * (itoa_pkg::LEN_W+6)'(43);
		return itoa_pkg::LEN_W'(p >> 7);
	endfunction

	assign accept = req.valid && req.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			itoa_pkg::FR_IDLE: begin
				if (req.valid) state_d = itoa_pkg::FR_CONV;
			end
			itoa_pkg::FR_CONV: begin
				if (pos_q == itoa_pkg::POS_W'(1)) state_d = itoa_pkg::FR_DONE;
			end
			itoa_pkg::FR_DONE: begin
				if (!stat.full) state_d = itoa_pkg::FR_IDLE;
			end
			default: state_d = itoa_pkg::FR_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		req.ready = 1'b0;
		push      = 1'b0;
		unique case (state_q)
			itoa_pkg::FR_IDLE: req.ready = 1'b1;
			itoa_pkg::FR_CONV: ;
			itoa_pkg::FR_DONE: push = !stat.full;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itoa_pkg::FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// clamp the minimum length
	assign pad_clamped = (req.min_digits > itoa_pkg::MIN_W'(itoa_pkg::PAD_LIMIT))
		? itoa_pkg::LEN_W'(itoa_pkg::PAD_LIMIT) : itoa_pkg::LEN_W'(req.min_digits);

	// conversion datapath, two bits per cycle from the top
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q   <= req.value[itoa_pkg::VALUE_BITS-1:0];
			shift_q <= itoa_pkg::DD_BITS'(req.value[itoa_pkg::VALUE_BITS-1:0]);
			bcd_q   <= '0;
			pos_q   <= itoa_pkg::POS_W'(itoa_pkg::DD_BITS - 1);
			msb_q   <= '0;
			found_q <= 1'b0;
			radix_q <= itoa_pkg::radix_t'(req.radix);
			pad_q   <= pad_clamped;
			grp_q   <= req.group;
		end else if (state_q == itoa_pkg::FR_CONV) begin
			bcd_q   <= dd_bit(dd_bit(bcd_q, shift_q[itoa_pkg::DD_BITS-1]),
			                  shift_q[itoa_pkg::DD_BITS-2]);
			shift_q <= shift_q << 2;
			pos_q   <= pos_q - itoa_pkg::POS_W'(2);
			// track the highest set bit for the power of two radixes
			if (!found_q) begin
				if (shift_q[itoa_pkg::DD_BITS-1]) begin
					msb_q   <= pos_q;
					found_q <= 1'b1;
				end else if (shift_q[itoa_pkg::DD_BITS-2]) begin
					msb_q   <= pos_q - itoa_pkg::POS_W'(1);
					found_q <= 1'b1;
				end
			end
		end
	end

	// decimal digit count: highest nonzero bcd digit
	always_comb begin
		ndig_dec = itoa_pkg::LEN_W'(1);
		for (int k = 0; k < itoa_pkg::DEC_DEPTH; k++) begin
			if (bcd_q[4*k +: 4] != 4'd0) ndig_dec = itoa_pkg::LEN_W'(k + 1);
		end
	end

	assign msb_ext = itoa_pkg::LEN_W'(msb_q);

	// natural digit count per radix
	always_comb begin
		unique case (radix_q)
			itoa_pkg::RADIX_DEC: ndig = ndig_dec;
			itoa_pkg::RADIX_BIN: ndig = msb_ext + itoa_pkg::LEN_W'(1);
			itoa_pkg::RADIX_OCT: ndig = div3(msb_ext) + itoa_pkg::LEN_W'(1);
			itoa_pkg::RADIX_HEX: ndig = (msb_ext >> 2) + itoa_pkg::LEN_W'(1);
			default:             ndig = ndig_dec;
		endcase
	end

	// separators, padding and total length
	assign grp_eff     = grp_q && (radix_q == itoa_pkg::RADIX_DEC);
	assign top_ext     = ndig - itoa_pkg::LEN_W'(1);
	assign top_div     = div3(top_ext);
	assign nsep        = grp_eff ? top_div : '0;
	assign natural_len = ndig + nsep;

	always_comb begin
		len = (natural_len < pad_q) ? pad_q : natural_len;
		if (len > itoa_pkg::LEN_W'(itoa_pkg::CAPACITY)) len = itoa_pkg::LEN_W'(itoa_pkg::CAPACITY);
	end

	// job for the back
	always_comb begin
		job.is_dec = (radix_q == itoa_pkg::RADIX_DEC);
		job.grp    = grp_eff;
		job.radix  = radix_q;
		job.len    = len;
		job.pad    = len - natural_len;
		job.top    = itoa_pkg::DIG_W'(top_ext);
		job.top_m3 = 2'(top_ext - (top_div << 1) - top_div);
		job.data   = (radix_q == itoa_pkg::RADIX_DEC)
			? itoa_pkg::DATA_W'(bcd_q) : itoa_pkg::DATA_W'(val_q);
	end

endmodule

>>> src/itoa_fifo.sv
// short job queue between the front and the back
module itoa_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  itoa_pkg::job_t       push_job,
	input  logic                 pop,
	output itoa_pkg::job_t       head,
	output itoa_pkg::fifo_stat_t stat
);

	itoa_pkg::job_t                  mem_q [itoa_pkg::FIFO_DEPTH];
	logic [itoa_pkg::FIFO_PTR_W-1:0] wr_q;
	logic [itoa_pkg::FIFO_PTR_W-1:0] rd_q;
	logic [itoa_pkg::FIFO_CNT_W-1:0] cnt_q;
	logic                            do_push;
	logic                            do_pop;

	assign stat.full  = (cnt_q == itoa_pkg::FIFO_CNT_W'(itoa_pkg::FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + itoa_pkg::FIFO_PTR_W'(1);
			if (do_pop)  rd_q <= rd_q + itoa_pkg::FIFO_PTR_W'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + itoa_pkg::FIFO_CNT_W'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - itoa_pkg::FIFO_CNT_W'(1);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_job;
	end

endmodule

>>> src/itoa_back.sv
// back: walks one job and emits its characters, most significant first
module itoa_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  itoa_pkg::job_t                head,
	input  itoa_pkg::fifo_stat_t          stat,
	output logic                          pop,
	input  logic [itoa_pkg::CHAR_W-1:0]   sep,
	itoa_char_if.source                   chr
);

	itoa_pkg::job_t               cur_q;
	logic                         active_q;
	logic                         ovalid_q;
	logic [itoa_pkg::CHAR_W-1:0]  och_q;
	logic                         olast_q;
	logic [itoa_pkg::IDX_W-1:0]   idx_q;
	logic [itoa_pkg::LEN_W-1:0]   pad_q;
	logic [itoa_pkg::DIG_W-1:0]   dig_q;
	logic [1:0]                   m3_q;
	logic                         sep_pend_q;

	logic                         adv;
	logic                         emit;
	logic [itoa_pkg::CHAR_W-1:0]  ch;
	logic                         last;
	logic [itoa_pkg::IDX_W-1:0]   idx_n;
	logic [itoa_pkg::LEN_W-1:0]   pad_n;
	logic [itoa_pkg::DIG_W-1:0]   dig_n;
	logic [1:0]                   m3_n;
	logic                         sep_n;
	logic [3:0]                   bcd_d;
	logic [itoa_pkg::IDX_W+1:0]   bit_pos;
	logic [itoa_pkg::DATA_W-1:0]  shifted;
	logic [3:0]                   raw_d;

	assign adv  = !ovalid_q || chr.ready;
	assign emit = active_q && adv;
	assign pop  = !active_q && !stat.empty;

	assign chr.valid     = ovalid_q;
	assign chr.character = och_q;
	assign chr.last      = olast_q;

	// digit pick for the current position
	assign bcd_d = cur_q.data[{dig_q, 2'b00} +: 4];

	always_comb begin
		unique case (cur_q.radix)
			itoa_pkg::RADIX_OCT: bit_pos = ({2'b00, idx_q} << 1) + {2'b00, idx_q};
			itoa_pkg::RADIX_HEX: bit_pos = {idx_q, 2'b00};
			default:             bit_pos = {2'b00, idx_q};
		endcase
	end

	assign shifted = cur_q.data >> bit_pos;

	always_comb begin
		unique case (cur_q.radix)
			itoa_pkg::RADIX_OCT: raw_d = {1'b0, shifted[2:0]};
			itoa_pkg::RADIX_HEX: raw_d = shifted[3:0];
			default:             raw_d = {3'b000, shifted[0]};
		endcase
	end

	// next character and counter updates
	always_comb begin
		ch    = itoa_pkg::CHAR_ZERO;
		last  = 1'b0;
		idx_n = idx_q;
		pad_n = pad_q;
		dig_n = dig_q;
		m3_n  = m3_q;
		sep_n = sep_pend_q;
		if (cur_q.is_dec) begin
			priority if (pad_q != '0) begin
				ch    = itoa_pkg::CHAR_ZERO;
				pad_n = pad_q - itoa_pkg::LEN_W'(1);
			end else if (sep_pend_q) begin
				ch    = sep;
				sep_n = 1'b0;
			end else begin
				ch    = itoa_pkg::DIGIT_CHARS[bcd_d];
				last  = (dig_q == '0);
				dig_n = dig_q - itoa_pkg::DIG_W'(1);
				m3_n  = (m3_q == 2'd0) ? 2'd2 : m3_q - 2'd1;
				// separator goes before every third digit counted from the right
				sep_n = cur_q.grp && (dig_q != '0) && (m3_n == 2'd2);
			end
		end else begin
			ch    = itoa_pkg::DIGIT_CHARS[raw_d];
			last  = (idx_q == '0);
			idx_n = idx_q - itoa_pkg::IDX_W'(1);
		end
	end

	// job control and output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (pop) active_q <= 1'b1;
			else if (emit && last) active_q <= 1'b0;
			if (adv) ovalid_q <= active_q;
		end
	end

	// job payload, counters and character register
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q      <= head;
			idx_q      <= itoa_pkg::IDX_W'(head.len - itoa_pkg::LEN_W'(1));
			pad_q      <= head.pad;
			dig_q      <= head.top;
			m3_q       <= head.top_m3;
			sep_pend_q <= 1'b0;
		end else if (emit) begin
			idx_q      <= idx_n;
			pad_q      <= pad_n;
			dig_q      <= dig_n;
			m3_q       <= m3_n;
			sep_pend_q <= sep_n;
		end
		if (emit) begin
			och_q   <= ch;
			olast_q <= last;
		end
	end

endmodule

>>> src/integer_to_ascii_formatter_top.sv
// Integer to ASCII formatter. A request carries a 64-bit unsigned value, a radix
// (0 decimal, 1 binary, 2 octal, 3 lower-case hex), a minimum length and a
// grouping flag; the block answers with the text one character per transfer on
// the character channel, most significant first, with last set on the final
// character. Text is zero-padded on the left to the minimum length (clamped to
// 64). In decimal with grouping, the separator register (reset ',') goes before
// every third digit from the right, but never ahead of the leading digit or
// among padding zeros. The converter runs 32 double dabble steps at two bits
// a cycle, after an accept state and before a length and push state, whatever
// the radix; the emitter loads each job and then sends its characters. A
// two-entry job queue lets the two overlap, so a new number can be converted
// while an older one is sent. Write the separator only while the block is idle.
module integer_to_ascii_formatter_top (
	input  logic                        clk,
	input  logic                        arst_n,
	itoa_req_if.sink                    req,
	itoa_char_if.source                 chr,
	input  logic                        cfg_we,
	input  logic [itoa_pkg::CHAR_W-1:0] cfg_wdata
);

	logic [itoa_pkg::CHAR_W-1:0] sep_q;
	itoa_pkg::job_t              push_job;
	itoa_pkg::job_t              head;
	itoa_pkg::fifo_stat_t        stat;
	logic                        push;
	logic                        pop;

	// separator register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q <= itoa_pkg::SEP_RESET;
		end else if (cfg_we) begin
			sep_q <= cfg_wdata;
		end
	end

	itoa_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.stat   (stat),
		.push   (push),
		.job    (push_job)
	);

	itoa_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	itoa_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.stat   (stat),
		.pop    (pop),
		.sep    (sep_q),
		.chr    (chr)
	);

endmodule
